[sv/gws_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package gws_pkg;

    // grid and word capacity
    localparam int MAX_ROWS = 32;
    localparam int MAX_COLS = 32;
    localparam int MAX_WORD = 32;
    localparam int NUM_DIRS = 8;

    // field and counter widths
    localparam int ROW_W    = 5;
    localparam int COL_W    = 5;
    localparam int POS_W    = 5;
    localparam int CHAR_W   = 8;
    localparam int CFG_W    = 6;
    localparam int CFG_IDX_W = 2;
    localparam int DIR_W    = 3;
    localparam int CNT_W    = $clog2(MAX_WORD + 1);
    localparam int WADDR_W  = $clog2(MAX_WORD);
    localparam int GADDR_W  = ROW_W + COL_W;
    localparam int GDEPTH   = MAX_ROWS * MAX_COLS;
    localparam int COORD_W  = 7;

    // command codes
    typedef enum logic [1:0] {
        CMD_GRID_WR = 2'd0,
        CMD_WORD_WR = 2'd1,
        CMD_QUERY   = 2'd2,
        CMD_NOP     = 2'd3
    } cmd_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_ROWS = 2'd0,
        CFG_NUM_COLS = 2'd1,
        CFG_WORD_LEN = 2'd2,
        CFG_UNUSED   = 2'd3
    } cfg_idx_t;

    // input and result items
    typedef struct packed {
        logic [1:0]        cmd;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [POS_W-1:0]  word_pos;
        logic [CHAR_W-1:0] char_value;
    } in_item_t;

    typedef struct packed {
        logic             found;
        logic [DIR_W-1:0] match_direction;
    } out_item_t;

    // controller state
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESULT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic load_query;
        logic scan_en;
        logic push_out;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_done;
        logic out_free;
    } dp_status_t;

    // row step per direction: down, up, right, left, dr, dl, ur, ul
    function automatic logic signed [1:0] dir_dr(input logic [DIR_W-1:0] d);
        logic signed [1:0] v;
        case (d)
            3'd0, 3'd4, 3'd5: v = 2'sd1;
            3'd1, 3'd6, 3'd7: v = -2'sd1;
            default:          v = 2'sd0;
        endcase
        return v;
    endfunction

    // column step per direction
    function automatic logic signed [1:0] dir_dc(input logic [DIR_W-1:0] d);
        logic signed [1:0] v;
        case (d)
            3'd2, 3'd4, 3'd6: v = 2'sd1;
            3'd3, 3'd5, 3'd7: v = -2'sd1;
            default:          v = 2'sd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

[sv/grid_word_search_8dir_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// grid and word writes complete on acceptance; a result transfer is not needed for them
// a query scans each direction through the single grid read port, one character
// per cycle, with the compare in the cycle after the read
// a query ends early on the first matching direction
// reset clears control and sets num_rows 32, num_cols 32, word_length 1;
// grid and word contents are undefined until written
module grid_word_search_8dir_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire gws_pkg::in_item_t             in_data,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output gws_pkg::out_item_t                 out_data,
    input  wire logic                          cfg_we,
    input  wire logic [gws_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [gws_pkg::CFG_W-1:0]     cfg_data
);
    import gws_pkg::*;

    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;

    // control sequencer
    gws_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_cmd   (in_data.cmd),
        .in_stall (in_stall),
        .status   (dp_status),
        .cmd      (dp_cmd)
    );

    // storage, scan and output stage
    gws_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (dp_cmd),
        .status    (dp_status),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

[sv/gws_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module gws_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic [1:0]         in_cmd,
    output logic                    in_stall,
    input  wire gws_pkg::dp_status_t status,
    output gws_pkg::dp_cmd_t        cmd
);
    import gws_pkg::*;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && (in_cmd == CMD_QUERY))
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (status.scan_done)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_stall       = (state_reg != ST_IDLE);
        cmd.accept     = (state_reg == ST_IDLE) && in_valid;
        cmd.load_query = (state_reg == ST_IDLE) && in_valid && (in_cmd == CMD_QUERY);
        cmd.scan_en    = (state_reg == ST_SCAN);
        cmd.push_out   = (state_reg == ST_RESULT) && status.out_free;
    end

endmodule

`default_nettype wire

[sv/gws_dp.sv]
`timescale 1ns / 1ps
`default_nettype none

module gws_dp (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire gws_pkg::in_item_t         in_data,
    input  wire logic                      cfg_we,
    input  wire logic [gws_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [gws_pkg::CFG_W-1:0] cfg_data,
    input  wire gws_pkg::dp_cmd_t          cmd,
    output gws_pkg::dp_status_t            status,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output gws_pkg::out_item_t             out_data
);
    import gws_pkg::*;

    // storage
    logic [CHAR_W-1:0] grid_mem [GDEPTH];
    logic [CHAR_W-1:0] word_mem [MAX_WORD];
    logic [CHAR_W-1:0] grid_q_reg;
    logic [CHAR_W-1:0] word_q_reg;

    // configuration
    logic [CFG_W-1:0] num_rows_reg;
    logic [CFG_W-1:0] num_cols_reg;
    logic [CFG_W-1:0] word_len_reg;
    logic [CFG_W-1:0] rows_eff;
    logic [CFG_W-1:0] cols_eff;
    logic [CFG_W-1:0] len_eff;

    // scan state
    logic [ROW_W-1:0]          row0_reg;
    logic [COL_W-1:0]          col0_reg;
    logic signed [COORD_W-1:0] r_reg;
    logic signed [COORD_W-1:0] c_reg;
    logic [DIR_W-1:0]          dir_reg;
    logic [CNT_W-1:0]          k_reg;
    logic                      pend_valid_reg;
    logic                      pend_last_reg;
    logic                      found_res_reg;
    logic [DIR_W-1:0]          dir_res_reg;

    // output stage
    logic      out_valid_reg;
    out_item_t out_data_reg;

    // scan decode
    logic                      skip;
    logic                      mismatch;
    logic                      hit;
    logic                      issue_in;
    logic                      oob;
    logic                      dir_fail;
    logic                      last_dir;
    logic                      issue;
    logic                      done;
    logic signed [1:0]         dr;
    logic signed [1:0]         dc;
    logic [GADDR_W-1:0]        grid_waddr;
    logic [GADDR_W-1:0]        grid_raddr;
    logic                      grid_we;
    logic                      word_we;

    // clamp registers to their legal ranges
    always_comb
    begin
        if (num_rows_reg == '0)
            rows_eff = CFG_W'(1);
        else if (num_rows_reg > CFG_W'(MAX_ROWS))
            rows_eff = CFG_W'(MAX_ROWS);
        else
            rows_eff = num_rows_reg;

        if (num_cols_reg == '0)
            cols_eff = CFG_W'(1);
        else if (num_cols_reg > CFG_W'(MAX_COLS))
            cols_eff = CFG_W'(MAX_COLS);
        else
            cols_eff = num_cols_reg;

        if (word_len_reg > CFG_W'(MAX_WORD))
            len_eff = CFG_W'(MAX_WORD);
        else
            len_eff = word_len_reg;
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_rows_reg <= CFG_W'(MAX_ROWS);
            num_cols_reg <= CFG_W'(MAX_COLS);
            word_len_reg <= CFG_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_NUM_ROWS: num_rows_reg <= cfg_data;
                CFG_NUM_COLS: num_cols_reg <= cfg_data;
                CFG_WORD_LEN: word_len_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    // scan step decode
    always_comb
    begin
        dr       = dir_dr(dir_reg);
        dc       = dir_dc(dir_reg);
        skip     = (len_eff == '0)
                   || ({1'b0, row0_reg} >= rows_eff)
                   || ({1'b0, col0_reg} >= cols_eff);
        mismatch = pend_valid_reg && (grid_q_reg != word_q_reg);
        hit      = pend_valid_reg && !mismatch && pend_last_reg;
        issue_in = (k_reg < len_eff);
        oob      = r_reg[COORD_W-1] || (r_reg[CFG_W-1:0] >= rows_eff)
                   || c_reg[COORD_W-1] || (c_reg[CFG_W-1:0] >= cols_eff);
        dir_fail = mismatch || (issue_in && oob);
        last_dir = (dir_reg == DIR_W'(NUM_DIRS - 1));
        done     = skip || hit || (dir_fail && last_dir);
        issue    = cmd.scan_en && !done && !dir_fail && issue_in;
    end

    assign status.scan_done = cmd.scan_en && done;
    assign status.out_free  = !out_valid_reg || !out_stall;

    // write and read addresses
    assign grid_waddr = {in_data.row, in_data.col};
    assign grid_raddr = {r_reg[ROW_W-1:0], c_reg[COL_W-1:0]};
    assign grid_we    = cmd.accept && (in_data.cmd == CMD_GRID_WR);
    assign word_we    = cmd.accept && (in_data.cmd == CMD_WORD_WR);

    // grid memory, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (grid_we)
        begin
            grid_mem[grid_waddr] <= in_data.char_value;
        end
        if (issue)
        begin
            grid_q_reg <= grid_mem[grid_raddr];
        end
    end

    // word memory, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (word_we)
        begin
            word_mem[in_data.word_pos] <= in_data.char_value;
        end
        if (issue)
        begin
            word_q_reg <= word_mem[k_reg[WADDR_W-1:0]];
        end
    end

    // query start cell
    always_ff @(posedge clk)
    begin
        if (cmd.load_query)
        begin
            row0_reg <= in_data.row;
            col0_reg <= in_data.col;
        end
    end

    // walk along one direction, compare in the cycle after the read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_reg          <= '0;
            c_reg          <= '0;
            dir_reg        <= '0;
            k_reg          <= '0;
            pend_valid_reg <= 1'b0;
            pend_last_reg  <= 1'b0;
        end
        else if (cmd.load_query)
        begin
            r_reg          <= COORD_W'(in_data.row);
            c_reg          <= COORD_W'(in_data.col);
            dir_reg        <= '0;
            k_reg          <= '0;
            pend_valid_reg <= 1'b0;
            pend_last_reg  <= 1'b0;
        end
        else if (cmd.scan_en && !done)
        begin
            if (dir_fail)
            begin
                r_reg          <= COORD_W'(row0_reg);
                c_reg          <= COORD_W'(col0_reg);
                dir_reg        <= dir_reg + DIR_W'(1);
                k_reg          <= '0;
                pend_valid_reg <= 1'b0;
                pend_last_reg  <= 1'b0;
            end
            else if (issue_in)
            begin
                r_reg          <= r_reg + {{(COORD_W-2){dr[1]}}, dr};
                c_reg          <= c_reg + {{(COORD_W-2){dc[1]}}, dc};
                k_reg          <= k_reg + CNT_W'(1);
                pend_valid_reg <= 1'b1;
                pend_last_reg  <= ((k_reg + CNT_W'(1)) == len_eff);
            end
            else
            begin
                pend_valid_reg <= 1'b0;
            end
        end
    end

    // query result
    always_ff @(posedge clk)
    begin
        if (cmd.scan_en && done)
        begin
            found_res_reg <= hit && !skip;
            dir_res_reg   <= (hit && !skip) ? dir_reg : '0;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.push_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push_out)
        begin
            out_data_reg.found           <= found_res_reg;
            out_data_reg.match_direction <= dir_res_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire
